// ----- hdl/hep_pkg.sv -----
// ----------------------------------------------------------------------------
// Histogram entropy and percentile package
// Shared types and fixed-point constants for the core.
// ----------------------------------------------------------------------------
package hep_pkg;

    localparam int unsigned DEFAULT_MAX_BINS = 4096;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [20:0] ENTROPY_MAX = 21'd1507328;
    localparam logic [43:0] CUM_MAX = {44{1'b1}};
    localparam logic [16:0] P_ONE = 17'd65536;

    // Configuration register indexes.
    localparam logic [0:0] REG_SAMPLE_COUNT = 1'b0;
    localparam logic [0:0] REG_THRESHOLD    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG_SETUP,
        ST_LOG_ITER,
        ST_LOG_SCALE,
        ST_BIN_MUL,
        ST_BIN_ACC,
        ST_N_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // Operand selected for the logarithm unit.
    typedef enum logic {
        LOG_SRC_BIN,
        LOG_SRC_N
    } log_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        log_src_t log_src;
        logic     log_setup;
        logic     log_iter;
        logic     log_scale;
        logic     bin_mul;
        logic     bin_acc;
        logic     n_mul;
        logic     div_step;
        logic     result_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic log_done;
        logic div_done;
        logic last;
    } dp_status_t;

endpackage

// ----- hdl/hep_ctrl.sv -----
// ----------------------------------------------------------------------------
// Histogram entropy and percentile controller
// Sequences the log and multiply-accumulate steps for each bin, then the divide.
// ----------------------------------------------------------------------------
module hep_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  hep_pkg::dp_status_t status,
    output hep_pkg::dp_cmd_t    cmd
);
    import hep_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   log_n_reg, log_n_next;

    // State, output-valid and log-phase registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            log_n_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            log_n_reg     <= log_n_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        log_n_next     = log_n_reg;
        cmd            = '0;
        cmd.log_src    = log_n_reg ? LOG_SRC_N : LOG_SRC_BIN;
        case (state_reg)
            ST_IDLE: begin
                log_n_next = 1'b0;
                if (s_axis_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOG_SETUP;
                end
            end
            ST_LOG_SETUP: begin
                cmd.log_setup = 1'b1;
                state_next    = ST_LOG_ITER;
            end
            ST_LOG_ITER: begin
                cmd.log_iter = 1'b1;
                if (status.log_done) state_next = ST_LOG_SCALE;
            end
            // The final log of a frame, after the last bin's, is that of the sample count.
            ST_LOG_SCALE: begin
                cmd.log_scale = 1'b1;
                state_next    = log_n_reg ? ST_N_MUL : ST_BIN_MUL;
            end
            ST_BIN_MUL: begin
                cmd.bin_mul = 1'b1;
                state_next  = ST_BIN_ACC;
            end
            ST_BIN_ACC: begin
                cmd.bin_acc = 1'b1;
                if (status.last) begin
                    cmd.log_src   = LOG_SRC_N;
                    cmd.log_setup = 1'b1;
                    log_n_next    = 1'b1;
                    state_next    = ST_LOG_ITER;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_N_MUL: begin
                cmd.n_mul  = 1'b1;
                log_n_next = 1'b0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_axis_tready) begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hdl/hep_datapath.sv -----
// ----------------------------------------------------------------------------
// Histogram entropy and percentile datapath
// Log unit, running sums, percentile test and bit-serial divider.
// ----------------------------------------------------------------------------
module hep_datapath #(
    parameter int unsigned MAX_BINS = hep_pkg::DEFAULT_MAX_BINS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [31:0]         in_bin_count,
    input  logic                in_last_bin,
    input  hep_pkg::dp_cmd_t    cmd,
    output hep_pkg::dp_status_t status,
    output logic [20:0]         entropy,
    output logic [11:0]         percentile_bin,
    output logic                percentile_found,
    output logic                no_samples
);
    import hep_pkg::*;

    localparam int PosW = $clog2(MAX_BINS);

    logic [31:0]     n_reg;
    logic [16:0]     p_reg;
    logic [31:0]     c_reg;
    logic            last_reg;
    logic [PosW-1:0] pos_reg;
    logic [43:0]     cum_reg;
    logic            hit_reg;
    logic [PosW-1:0] hit_pos_reg;
    logic [63:0]     wls_reg;
    logic [32:0]     m_reg;
    logic [19:0]     frac_reg;
    logic [4:0]      k_reg;
    logic [4:0]      iter_reg;
    logic [31:0]     ln_reg;
    logic [63:0]     prod_reg;
    logic [63:0]     rem_reg;
    logic [63:0]     quo_reg;
    logic [6:0]      div_cnt_reg;
    logic [20:0]     ent_reg;
    logic [11:0]     pbin_reg;
    logic            found_reg;
    logic            nos_reg;

    // Leading-one position of the log operand.
    logic [31:0] log_x;
    logic [4:0]  lead;
    always_comb begin
        log_x = (cmd.log_src == LOG_SRC_N) ? n_reg : c_reg;
        lead  = '0;
        for (int i = 0; i < 32; i++) begin
            if (log_x[i]) lead = 5'(i);
        end
    end

    // One squaring step of the mantissa.
    logic [65:0] sq;
    logic [34:0] sq_sh;
    assign sq    = 66'(m_reg) * 66'(m_reg);
    assign sq_sh = sq[65:31];

    // Percentile test on the new running total.
    logic [44:0] cum_sum;
    logic [43:0] cum_new;
    logic [16:0] p_eff;
    logic [59:0] lhs;
    logic [59:0] rhs;
    assign cum_sum = 45'(cum_reg) + 45'(c_reg);
    assign cum_new = cum_sum[44] ? CUM_MAX : cum_sum[43:0];
    assign p_eff   = (p_reg > P_ONE) ? P_ONE : p_reg;
    assign lhs     = {cum_new, 16'd0};
    assign rhs     = 60'(p_eff) * 60'(n_reg);

    // Log scaling product.
    logic [56:0] l2;
    logic [88:0] l2_prod;
    assign l2      = 57'({k_reg, frac_reg});
    assign l2_prod = 89'(l2) * 89'(LN2_Q32) + (89'(1) << 35);

    // Weighted term and saturating sum.
    logic [63:0] term_reg;
    logic [64:0] wls_sum;
    assign wls_sum = 65'(wls_reg) + 65'(term_reg);

    // Restoring division step.
    logic [64:0] rem_sh;
    assign rem_sh = {rem_reg, quo_reg[63]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= '0;
            p_reg     <= 17'd32768;
            pos_reg   <= '0;
            cum_reg   <= '0;
            hit_reg   <= 1'b0;
            hit_pos_reg <= '0;
            wls_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SAMPLE_COUNT: n_reg <= cfg_data;
                    REG_THRESHOLD:    p_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (cmd.bin_acc) begin
                wls_reg <= wls_sum[64] ? {64{1'b1}} : wls_sum[63:0];
                cum_reg <= cum_new;
                if (!hit_reg && lhs >= rhs) begin
                    hit_reg     <= 1'b1;
                    hit_pos_reg <= pos_reg;
                end
                if (!last_reg && pos_reg != PosW'(MAX_BINS - 1)) pos_reg <= pos_reg + 1'b1;
            end
            if (cmd.result_load) begin
                pos_reg     <= '0;
                cum_reg     <= '0;
                hit_reg     <= 1'b0;
                hit_pos_reg <= '0;
                wls_reg     <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            c_reg    <= in_bin_count;
            last_reg <= in_last_bin;
        end
        if (cmd.log_setup) begin
            k_reg    <= lead;
            m_reg    <= {1'b0, log_x << (5'd31 - lead)};
            frac_reg <= '0;
            iter_reg <= '0;
        end
        if (cmd.log_iter) begin
            iter_reg <= iter_reg + 1'b1;
            if (sq_sh[32]) begin
                m_reg    <= sq_sh[33:1];
                frac_reg <= {frac_reg[18:0], 1'b1};
            end else begin
                m_reg    <= sq_sh[32:0];
                frac_reg <= {frac_reg[18:0], 1'b0};
            end
        end
        if (cmd.log_scale) begin
            ln_reg <= (log_x == '0) ? '0 : l2_prod[67:36];
        end
        if (cmd.bin_mul) term_reg <= 64'(c_reg) * 64'(ln_reg);
        if (cmd.n_mul) begin
            prod_reg    <= 64'(n_reg) * 64'(ln_reg);
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            if (div_cnt_reg == 7'd0) begin
                rem_reg <= '0;
                quo_reg <= (wls_reg < prod_reg) ? prod_reg - wls_reg : '0;
            end else if (rem_sh >= 65'(n_reg)) begin
                rem_reg <= 64'(rem_sh - 65'(n_reg));
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.result_load) begin
            if (n_reg == '0) ent_reg <= '0;
            else if (quo_reg > 64'(ENTROPY_MAX)) ent_reg <= ENTROPY_MAX;
            else ent_reg <= quo_reg[20:0];
            pbin_reg  <= hit_reg ? 12'(hit_pos_reg) : '0;
            found_reg <= hit_reg;
            nos_reg   <= (n_reg == '0);
        end
    end

    assign status.log_done = (iter_reg == 5'd19);
    assign status.div_done = (div_cnt_reg == 7'd65);
    assign status.last     = last_reg;

    assign entropy          = ent_reg;
    assign percentile_bin   = pbin_reg;
    assign percentile_found = found_reg;
    assign no_samples       = nos_reg;

endmodule

// ----- hdl/histogram_entropy_percentile_core.sv -----
// ----------------------------------------------------------------------------
// Histogram entropy and percentile core
// Accumulates bin counts and reports entropy and a percentile bin per frame.
// ----------------------------------------------------------------------------
// Usage: bin counts arrive one item per bin on the s_axis channel, tlast on
// the final bin. Each bin passes through the 20-step log squaring loop plus
// setup, scaling and multiply-accumulate, and a new bin is accepted only
// once the previous one is through. The final bin adds a second log of the
// sample count and a 64-step bit-serial divide before the result item appears.
// One result item per frame leaves on m_axis; it is held in an output
// register until taken, and while it waits the next frame's bins are still
// accepted. A new result waits for the previous one to drain.
// Configuration must be written through cfg_wr_en, cfg_index and cfg_data
// while idle; the block does not enforce this. Reset (aresetn low, synchronous)
// clears the sums, sets the sample count to zero and the threshold to one half.
// ----------------------------------------------------------------------------
module histogram_entropy_percentile_core #(
    parameter int unsigned MAX_BINS = hep_pkg::DEFAULT_MAX_BINS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // bin_count
    input  logic        s_axis_tlast,   // last_bin
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // entropy, percentile_bin, found, no_samples
);
    import hep_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [20:0] entropy;
    logic [11:0] percentile_bin;
    logic        percentile_found;
    logic        no_samples;

    hep_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    hep_datapath #(.MAX_BINS(MAX_BINS)) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_bin_count     (s_axis_tdata),
        .in_last_bin      (s_axis_tlast),
        .cmd              (cmd),
        .status           (status),
        .entropy          (entropy),
        .percentile_bin   (percentile_bin),
        .percentile_found (percentile_found),
        .no_samples       (no_samples)
    );

    assign m_axis_tdata = {5'd0, no_samples, percentile_found, percentile_bin, entropy};

endmodule
